FILE: rtl/okvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okvt_pkg: shared types and constants of the ordered key/value table
// Field widths, operation codes, request and result structs and width helpers.
// ----------------------------------------------------------------------------
package okvt_pkg;

   // default sizes of the storage
   localparam int DEPTH_DEF      = 16;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   // fixed field widths on the ports
   localparam int KIND_W  = 3;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int CAP_W   = 5;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_PAD_W  = RSP_DATA_W - VALUE_W - KEY_W - COUNT_W;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_SET      = 3'd0,
      KIND_GET      = 3'd1,
      KIND_DELETE   = 3'd2,
      KIND_KEY_AT   = 3'd3,
      KIND_VALUE_AT = 3'd4,
      KIND_CLEAR    = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic [POS_W-1:0]     position;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [VALUE_W-1:0]   found_value;
      logic [KEY_W-1:0]     found_key;
      logic [COUNT_W-1:0]   count;
   } rsp_type;

   // address bits for a table of the given depth
   function automatic int idx_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // bits to hold an entry count from zero up to the depth
   function automatic int cnt_bits(input int depth);
      return $clog2(depth + 1);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/okvt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okvt_store: key and value memories
// One write port and one read port each, read data registered.
// ----------------------------------------------------------------------------
module okvt_store #(
   parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
   parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [okvt_pkg::idx_bits(DEPTH)-1:0]   wr_addr,
   input  wire logic [KEY_BITS-1:0]                    wr_key,
   input  wire logic [VALUE_BITS-1:0]                  wr_value,
   input  wire logic [okvt_pkg::idx_bits(DEPTH)-1:0]   rd_addr,
   output logic      [KEY_BITS-1:0]                    rd_key,
   output logic      [VALUE_BITS-1:0]                  rd_value
);

   logic [KEY_BITS-1:0]   key_mem   [DEPTH];
   logic [VALUE_BITS-1:0] value_mem [DEPTH];
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_value_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule
`default_nettype wire

FILE: rtl/okvt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okvt_ctrl: operation sequencer of the ordered key/value table
// Scans the key memory one entry a cycle, updates in place, appends, and
// closes the gap after a delete by copying each later entry down one slot.
// ----------------------------------------------------------------------------
module okvt_ctrl #(
   parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
   parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // operation in
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire okvt_pkg::req_type                      req,
   input  wire logic [okvt_pkg::CAP_W-1:0]             capacity,
   // result out
   output logic                                        res_valid,
   input  wire logic                                   res_ready,
   output okvt_pkg::rsp_type                           res,
   // memory ports
   output logic                                        mem_wr_en,
   output logic      [okvt_pkg::idx_bits(DEPTH)-1:0]   mem_wr_addr,
   output logic      [KEY_BITS-1:0]                    mem_wr_key,
   output logic      [VALUE_BITS-1:0]                  mem_wr_value,
   output logic      [okvt_pkg::idx_bits(DEPTH)-1:0]   mem_rd_addr,
   input  wire logic [KEY_BITS-1:0]                    mem_rd_key,
   input  wire logic [VALUE_BITS-1:0]                  mem_rd_value
);

   localparam int IDX_W = okvt_pkg::idx_bits(DEPTH);
   localparam int CNT_W = okvt_pkg::cnt_bits(DEPTH);
   localparam int EXT_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > okvt_pkg::CAP_W) ? CNT_W : okvt_pkg::CAP_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_MISS  = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   okvt_pkg::kind_type    kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  ok_ff, ok_in;
   logic [VALUE_BITS-1:0] fv_ff, fv_in;
   logic [KEY_BITS-1:0]   fk_ff, fk_in;

   logic [EXT_W-1:0]      idx_ext;
   logic [EXT_W-1:0]      idx_p1;
   logic [EXT_W-1:0]      idx_p2;
   logic [EXT_W-1:0]      cnt_ext;
   logic                  key_hit;
   logic                  room;
   logic                  pos_ok;

   // index arithmetic and compares
   assign idx_ext = (EXT_W)'(idx_ff);
   assign idx_p1  = idx_ext + (EXT_W)'(1);
   assign idx_p2  = idx_ext + (EXT_W)'(2);
   assign cnt_ext = (EXT_W)'(count_ff);
   assign key_hit = (mem_rd_key == key_ff);
   assign room    = ((CMP_W)'(count_ff) < (CMP_W)'(capacity)) &&
                    ((CMP_W)'(count_ff) < (CMP_W)'(DEPTH));
   assign pos_ok  = (req.position != '0) &&
                    ((CMP_W)'(req.position) <= (CMP_W)'(count_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      ok_in        = ok_ff;
      fv_in        = fv_ff;
      fk_in        = fk_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_key   = key_ff;
      mem_wr_value = value_ff;
      mem_rd_addr  = idx_p1[IDX_W-1:0];
      req_ready    = (state_ff == ST_IDLE);
      res_valid    = (state_ff == ST_DONE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req.kind;
               key_in   = (KEY_BITS)'(req.key);
               value_in = (VALUE_BITS)'(req.value);
               ok_in    = 1'b0;
               fv_in    = '0;
               fk_in    = '0;
               idx_in   = '0;
               case (req.kind)
                  okvt_pkg::KIND_SET, okvt_pkg::KIND_GET, okvt_pkg::KIND_DELETE: begin
                     // start the scan at the first entry
                     mem_rd_addr = '0;
                     if (count_ff == '0) begin
                        state_in = ST_MISS;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  okvt_pkg::KIND_KEY_AT, okvt_pkg::KIND_VALUE_AT: begin
                     mem_rd_addr = (IDX_W)'(req.position - (okvt_pkg::POS_W)'(1));
                     state_in    = pos_ok ? ST_READ : ST_DONE;
                  end
                  okvt_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read data holds entry idx_ff, next entry is being read
            if (key_hit) begin
               ok_in = 1'b1;
               case (kind_ff)
                  okvt_pkg::KIND_SET: begin
                     mem_wr_en = 1'b1;
                     state_in  = ST_DONE;
                  end
                  okvt_pkg::KIND_GET: begin
                     fv_in    = mem_rd_value;
                     state_in = ST_DONE;
                  end
                  okvt_pkg::KIND_DELETE: begin
                     fv_in = mem_rd_value;
                     if (idx_p2 <= cnt_ext) begin
                        state_in = ST_SHIFT;
                     end else begin
                        count_in = count_ff - (CNT_W)'(1);
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else if (idx_p1 == cnt_ext) begin
               state_in = ST_MISS;
            end else begin
               idx_in = idx_p1[IDX_W-1:0];
            end
         end

         ST_MISS: begin
            // key not present: append on set if there is room
            if (kind_ff == okvt_pkg::KIND_SET && room) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = (IDX_W)'(count_ff);
               count_in    = count_ff + (CNT_W)'(1);
               ok_in       = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_SHIFT: begin
            // copy entry idx+1 down to idx, fetch entry idx+2
            mem_wr_en    = 1'b1;
            mem_wr_key   = mem_rd_key;
            mem_wr_value = mem_rd_value;
            mem_rd_addr  = idx_p2[IDX_W-1:0];
            if (idx_p2 < cnt_ext) begin
               idx_in = idx_p1[IDX_W-1:0];
            end else begin
               count_in = count_ff - (CNT_W)'(1);
               state_in = ST_DONE;
            end
         end

         ST_READ: begin
            ok_in = 1'b1;
            if (kind_ff == okvt_pkg::KIND_KEY_AT) begin
               fk_in = mem_rd_key;
            end else begin
               fv_in = mem_rd_value;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // operation and result payload
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      ok_ff    <= ok_in;
      fv_ff    <= fv_in;
      fk_ff    <= fk_in;
   end

   // result fields at port widths
   assign res.ok          = ok_ff;
   assign res.found_value = (okvt_pkg::VALUE_W)'(fv_ff);
   assign res.found_key   = (okvt_pkg::KEY_W)'(fk_ff);
   assign res.count       = (okvt_pkg::COUNT_W)'(count_ff);

endmodule
`default_nettype wire

FILE: rtl/ordered_key_value_table.sv
// Clear, the unused kinds and key-at or value-at at a bad position go straight
// to the result; key-at and value-at at a valid position read that entry first.
// Set, get and delete scan the key memory one entry per cycle through its
// single read port, from the first entry up to a hit or past the last entry
// on a miss; a delete then moves each later entry down one slot. The next
// operation is taken the cycle after the result moves to the rsp register,
// while that result waits there. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_key_value_table: bounded key/value table in insertion order
// Set, get, delete, key-at, value-at and clear over a linear-search table
// held in block memory, with a capacity register and a registered result.
// ----------------------------------------------------------------------------
module ordered_key_value_table #(
   parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
   parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // operation stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [okvt_pkg::REQ_DATA_W-1:0]      req_tdata,  // key, value, position
   input  wire logic [okvt_pkg::KIND_W-1:0]          req_tuser,  // kind
   // result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [okvt_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // found_value, found_key, count
   output logic                                      rsp_tuser,  // ok
   // capacity register write
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [okvt_pkg::CAP_W-1:0]           csr_wdata
);

   localparam int IDX_W = okvt_pkg::idx_bits(DEPTH);

   okvt_pkg::req_type          req;
   okvt_pkg::rsp_type          res;
   logic                       res_valid;
   logic                       res_ready;
   logic [okvt_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   okvt_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   logic [KEY_BITS-1:0]        mem_wr_key;
   logic [VALUE_BITS-1:0]      mem_wr_value;
   logic [IDX_W-1:0]           mem_rd_addr;
   logic [KEY_BITS-1:0]        mem_rd_key;
   logic [VALUE_BITS-1:0]      mem_rd_value;

   // unpack the operation
   assign req.kind     = okvt_pkg::kind_type'(req_tuser);
   assign req.key      = req_tdata[63:0];
   assign req.value    = req_tdata[95:64];
   assign req.position = req_tdata[100:96];

   // capacity register, always writable
   assign csr_ready   = 1'b1;
   assign capacity_in = csr_valid ? csr_wdata : capacity_ff;

   // result register between the sequencer and the rsp side
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= okvt_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {{okvt_pkg::RSP_PAD_W{1'b0}}, rsp_ff.count, rsp_ff.found_key,
                        rsp_ff.found_value};

   // sequencer
   okvt_ctrl #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .capacity     (capacity_ff),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_key   (mem_wr_key),
      .mem_wr_value (mem_wr_value),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_key   (mem_rd_key),
      .mem_rd_value (mem_rd_value)
   );

   // key and value memories
   okvt_store #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_key   (mem_wr_key),
      .wr_value (mem_wr_value),
      .rd_addr  (mem_rd_addr),
      .rd_key   (mem_rd_key),
      .rd_value (mem_rd_value)
   );

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ordered key/value table
// Runs a short table of directed operations, then random phases of set, get,
// delete, key-at, value-at and clear over a small key pool under several
// capacities, with random stalls on both streams. Every result is compared
// with its hand-written result or with an in-bench model of the table.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TABLE_DEPTH  = okvt_pkg::DEPTH_DEF;
   localparam int POOL_SIZE    = 20;
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 10;
   localparam int DRAIN_CYCLES = 25;
   localparam int REPORT_LIMIT = 10;

   // kinds the block must treat as no-ops
   localparam logic [okvt_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [okvt_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   localparam logic [okvt_pkg::KEY_W-1:0] KEY_ONES = {okvt_pkg::KEY_W{1'b1}};
   localparam logic [okvt_pkg::VALUE_W-1:0] VAL_ONES = {okvt_pkg::VALUE_W{1'b1}};

   // one operation as it travels on the request stream
   typedef struct packed {
      logic [okvt_pkg::KIND_W-1:0]  kind;
      logic [okvt_pkg::KEY_W-1:0]   key;
      logic [okvt_pkg::VALUE_W-1:0] value;
      logic [okvt_pkg::POS_W-1:0]   position;
   } op_type;

   // one result as it leaves on the response stream
   typedef struct packed {
      logic                         ok;
      logic [okvt_pkg::VALUE_W-1:0] found_value;
      logic [okvt_pkg::KEY_W-1:0]   found_key;
      logic [okvt_pkg::COUNT_W-1:0] count;
   } reply_type;

   // directed row: operation plus an optional hand-written result
   typedef struct packed {
      logic [okvt_pkg::KIND_W-1:0]  kind;
      logic [okvt_pkg::KEY_W-1:0]   key;
      logic [okvt_pkg::VALUE_W-1:0] value;
      logic [okvt_pkg::POS_W-1:0]   position;
      logic                         typed;
      logic                         ok;
      logic [okvt_pkg::VALUE_W-1:0] found_value;
      logic [okvt_pkg::KEY_W-1:0]   found_key;
      logic [okvt_pkg::COUNT_W-1:0] count;
   } row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty table right after reset
      '{okvt_pkg::KIND_GET,      64'h0, 32'h0, 5'd0, 1'b1, 1'b0, 32'h0, 64'h0, 5'd0},
      '{okvt_pkg::KIND_KEY_AT,   64'h0, 32'h0, 5'd1, 1'b1, 1'b0, 32'h0, 64'h0, 5'd0},
      // empty key and all-ones key are ordinary keys
      '{okvt_pkg::KIND_SET,      64'h0, VAL_ONES, 5'd0, 1'b1, 1'b1, 32'h0, 64'h0, 5'd1},
      '{okvt_pkg::KIND_SET,      KEY_ONES, 32'h0, 5'd31, 1'b1, 1'b1, 32'h0, 64'h0, 5'd2},
      '{okvt_pkg::KIND_GET,      64'h0, 32'h0, 5'd0, 1'b1, 1'b1, VAL_ONES, 64'h0, 5'd2},
      '{okvt_pkg::KIND_KEY_AT,   64'h0, 32'h0, 5'd2, 1'b1, 1'b1, 32'h0, KEY_ONES, 5'd2},
      '{okvt_pkg::KIND_VALUE_AT, 64'h0, 32'h0, 5'd1, 1'b1, 1'b1, VAL_ONES, 64'h0, 5'd2},
      // positions zero and past the count
      '{okvt_pkg::KIND_VALUE_AT, 64'h0, 32'h0, 5'd0, 1'b1, 1'b0, 32'h0, 64'h0, 5'd2},
      '{okvt_pkg::KIND_KEY_AT,   64'h0, 32'h0, 5'd3, 1'b1, 1'b0, 32'h0, 64'h0, 5'd2},
      '{okvt_pkg::KIND_VALUE_AT, 64'h0, 32'h0, 5'd31, 1'b1, 1'b0, 32'h0, 64'h0, 5'd2},
      // update in place, then two appends
      '{okvt_pkg::KIND_SET,      64'h0, 32'h1234_5678, 5'd0,
        1'b1, 1'b1, 32'h0, 64'h0, 5'd2},
      '{okvt_pkg::KIND_SET,      64'h1, 32'hA5A5_A5A5, 5'd0,
        1'b0, 1'b0, 32'h0, 64'h0, 5'd0},
      '{okvt_pkg::KIND_SET,      64'h8000_0000_0000_0000, 32'h5A5A_5A5A, 5'd16,
        1'b0, 1'b0, 32'h0, 64'h0, 5'd0},
      // delete the head and check the shift
      '{okvt_pkg::KIND_DELETE,   64'h0, 32'h0, 5'd0,
        1'b1, 1'b1, 32'h1234_5678, 64'h0, 5'd3},
      '{okvt_pkg::KIND_KEY_AT,   64'h0, 32'h0, 5'd1, 1'b1, 1'b1, 32'h0, KEY_ONES, 5'd3},
      '{okvt_pkg::KIND_KEY_AT,   64'h0, 32'h0, 5'd3, 1'b0, 1'b0, 32'h0, 64'h0, 5'd0},
      // missing keys
      '{okvt_pkg::KIND_DELETE,   64'h0, 32'h0, 5'd0, 1'b1, 1'b0, 32'h0, 64'h0, 5'd3},
      '{okvt_pkg::KIND_GET,      64'h5555_5555_5555_5555, 32'h0, 5'd0,
        1'b1, 1'b0, 32'h0, 64'h0, 5'd3},
      // unused kinds change nothing
      '{KIND_SPARE_HI, KEY_ONES, VAL_ONES, 5'd31, 1'b1, 1'b0, 32'h0, 64'h0, 5'd3},
      '{KIND_SPARE_LO, 64'h0, 32'h0, 5'd0, 1'b1, 1'b0, 32'h0, 64'h0, 5'd3},
      '{okvt_pkg::KIND_GET,      KEY_ONES, 32'h0, 5'd0, 1'b1, 1'b1, 32'h0, 64'h0, 5'd3},
      '{okvt_pkg::KIND_DELETE,   KEY_ONES, 32'h0, 5'd0, 1'b0, 1'b0, 32'h0, 64'h0, 5'd0},
      // clear, then nothing is left
      '{okvt_pkg::KIND_CLEAR,    64'h0, 32'h0, 5'd0, 1'b1, 1'b1, 32'h0, 64'h0, 5'd0},
      '{okvt_pkg::KIND_GET,      64'h1, 32'h0, 5'd0, 1'b1, 1'b0, 32'h0, 64'h0, 5'd0},
      '{okvt_pkg::KIND_VALUE_AT, 64'h0, 32'h0, 5'd1, 1'b1, 1'b0, 32'h0, 64'h0, 5'd0}
   };

   // capacities per random phase; the tail is drawn at random
   localparam logic [okvt_pkg::CAP_W-1:0] CAP_PLAN [7] = '{
      5'd16, 5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd8
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [okvt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [okvt_pkg::KIND_W-1:0]     req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [okvt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [okvt_pkg::CAP_W-1:0]      csr_wdata  = '0;

   // shadow of the table contents
   logic [okvt_pkg::KEY_W-1:0]   tbl_key [TABLE_DEPTH];
   logic [okvt_pkg::VALUE_W-1:0] tbl_val [TABLE_DEPTH];
   int                           tbl_count;
   int                           tbl_capacity;

   logic [okvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
   reply_type                  pending_replies [$];

   int mismatches  = 0;
   int ops_sent    = 0;
   int replies_got = 0;
   int cap_writes  = 0;
   int set_refused = 0;
   int peak_count  = 0;
   int source_mode = 0;
   int sink_mode   = 0;

   ordered_key_value_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // wait before a transfer: none, anywhere in 0..14, or mostly none
   function automatic int draw_wait(input int mode);
      if (mode == 0) begin
         return 0;
      end
      if (mode == 1) begin
         return $urandom_range(0, 14);
      end
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
   endfunction

   // apply one operation to the shadow table and give the result it yields
   task automatic table_apply(input op_type op, output reply_type r);
      int slot;
      int limit;
      int j;
      r = '0;
      slot = -1;
      for (j = 0; j < tbl_count; j++) begin
         if (slot < 0 && tbl_key[j] == op.key) begin
            slot = j;
         end
      end
      limit = (tbl_capacity < TABLE_DEPTH) ? tbl_capacity : TABLE_DEPTH;
      case (op.kind)
         okvt_pkg::KIND_SET: begin
            if (slot >= 0) begin
               tbl_val[slot] = op.value;
               r.ok = 1'b1;
            end else if (tbl_count < limit) begin
               tbl_key[tbl_count] = op.key;
               tbl_val[tbl_count] = op.value;
               tbl_count++;
               r.ok = 1'b1;
            end else begin
               set_refused++;
            end
         end
         okvt_pkg::KIND_GET: begin
            if (slot >= 0) begin
               r.found_value = tbl_val[slot];
               r.ok = 1'b1;
            end
         end
         okvt_pkg::KIND_DELETE: begin
            if (slot >= 0) begin
               r.found_value = tbl_val[slot];
               r.ok = 1'b1;
               // close the gap left by the removed entry
               for (j = slot; j + 1 < tbl_count; j++) begin
                  tbl_key[j] = tbl_key[j + 1];
                  tbl_val[j] = tbl_val[j + 1];
               end
               tbl_count--;
            end
         end
         okvt_pkg::KIND_KEY_AT: begin
            if (op.position >= 1 && op.position <= tbl_count) begin
               r.found_key = tbl_key[op.position - 1];
               r.ok = 1'b1;
            end
         end
         okvt_pkg::KIND_VALUE_AT: begin
            if (op.position >= 1 && op.position <= tbl_count) begin
               r.found_value = tbl_val[op.position - 1];
               r.ok = 1'b1;
            end
         end
         okvt_pkg::KIND_CLEAR: begin
            tbl_count = 0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.count = tbl_count[okvt_pkg::COUNT_W-1:0];
      if (tbl_count > peak_count) begin
         peak_count = tbl_count;
      end
   endtask

   // random operation, mostly on pooled keys so lookups hit and the table fills
   function automatic op_type random_op();
      op_type op;
      int     roll;
      roll = $urandom_range(0, 99);
      if (roll < 38)       op.kind = okvt_pkg::KIND_SET;
      else if (roll < 58)  op.kind = okvt_pkg::KIND_GET;
      else if (roll < 72)  op.kind = okvt_pkg::KIND_DELETE;
      else if (roll < 83)  op.kind = okvt_pkg::KIND_KEY_AT;
      else if (roll < 94)  op.kind = okvt_pkg::KIND_VALUE_AT;
      else if (roll < 96)  op.kind = okvt_pkg::KIND_CLEAR;
      else if (roll < 98)  op.kind = KIND_SPARE_LO;
      else                 op.kind = KIND_SPARE_HI;
      if ($urandom_range(0, 9) == 0) begin
         op.key = {$urandom, $urandom};
      end else begin
         op.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      op.value = $urandom;
      if ($urandom_range(0, 6) == 0) begin
         op.position = (okvt_pkg::POS_W)'($urandom_range(0, 31));
      end else begin
         op.position = (okvt_pkg::POS_W)'($urandom_range(0, TABLE_DEPTH + 1));
      end
      return op;
   endfunction

   // drive one operation and return at the edge of its transfer
   task automatic send_op(input op_type op);
      int gap;
      gap = draw_wait(source_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.kind;
      req_tdata  <= {{(okvt_pkg::REQ_DATA_W - okvt_pkg::POS_W - okvt_pkg::VALUE_W -
                       okvt_pkg::KEY_W){1'b0}},
                     op.position, op.value, op.key};
      do @(posedge clock); while (!req_tready);
      ops_sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // capacity write, only while the table is idle
   task automatic write_capacity(input logic [okvt_pkg::CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tbl_capacity = int'(cap);
      cap_writes++;
   endtask

   // stimulus: directed rows, then random phases under changing capacity
   initial begin
      op_type                     op;
      reply_type                  predicted;
      logic [okvt_pkg::CAP_W-1:0] cap;
      int                         i;
      int                         phase;

      for (i = 0; i < TABLE_DEPTH; i++) begin
         tbl_key[i] = '0;
         tbl_val[i] = '0;
      end
      tbl_count    = 0;
      tbl_capacity = int'(okvt_pkg::CAPACITY_RESET);

      // key pool with the extremes, single bits and random words
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
      for (i = 2; i < 6; i++) begin
         key_pool[i] = 64'h1 << $urandom_range(0, okvt_pkg::KEY_W - 1);
      end
      for (i = 6; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         op.kind     = DIRECTED[i].kind;
         op.key      = DIRECTED[i].key;
         op.value    = DIRECTED[i].value;
         op.position = DIRECTED[i].position;
         send_op(op);
         table_apply(op, predicted);
         if (DIRECTED[i].typed) begin
            pending_replies.push_back({DIRECTED[i].ok, DIRECTED[i].found_value,
                                       DIRECTED[i].found_key, DIRECTED[i].count});
         end else begin
            pending_replies.push_back(predicted);
         end
      end
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         cap = (phase < 7) ? CAP_PLAN[phase] :
                             (okvt_pkg::CAP_W)'($urandom_range(0, 31));
         write_capacity(cap);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) begin
               source_mode = $urandom_range(0, 2);
            end
            op = random_op();
            send_op(op);
            table_apply(op, predicted);
            pending_replies.push_back(predicted);
         end
         drain();
      end

      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_replies.size() != 0) begin
         mismatches++;
      end
      $display("covered %0d operations under %0d capacity settings, %0d results checked",
               ops_sent, cap_writes + 1, replies_got);
      $display("table peaked at %0d entries, %0d sets refused as full, %0d mismatches",
               peak_count, set_refused, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // result side: random stalls, compare each transfer with the oldest expectation
   initial begin
      int        stall;
      reply_type got;
      reply_type want;

      wait (reset == 1'b0);
      forever begin
         if (replies_got % 50 == 0) begin
            sink_mode = $urandom_range(0, 2);
         end
         stall = draw_wait(sink_mode);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.ok          = rsp_tuser;
         got.found_value = rsp_tdata[okvt_pkg::VALUE_W-1:0];
         got.found_key   = rsp_tdata[okvt_pkg::VALUE_W +: okvt_pkg::KEY_W];
         got.count       = rsp_tdata[okvt_pkg::VALUE_W + okvt_pkg::KEY_W +:
                                     okvt_pkg::COUNT_W];
         replies_got++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result %0d arrived with no operation outstanding", replies_got);
            end
         end else begin
            want = pending_replies.pop_front();
            if (got.ok !== want.ok || got.found_value !== want.found_value ||
                got.found_key !== want.found_key || got.count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("result %0d: expected ok=%0d value=%h key=%h count=%0d",
                           replies_got, want.ok, want.found_value, want.found_key,
                           want.count);
                  $display("result %0d:   actual ok=%0d value=%h key=%h count=%0d",
                           replies_got, got.ok, got.found_value, got.found_key,
                           got.count);
               end
            end
         end
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_replies.size());
      $display("status: fail");
      $finish;
   end

endmodule
